/* rtl/two_stream_timestamp_synchronizer_unit_assert.svh */
// Assertion macros shared by the timestamp synchronizer RTL
`ifndef TWO_STREAM_TIMESTAMP_SYNCHRONIZER_UNIT_ASSERT_SVH
`define TWO_STREAM_TIMESTAMP_SYNCHRONIZER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TSU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TSU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tsu_pkg.sv */
// Shared types, codes and widths of the timestamp synchronizer
package tsu_pkg;

	localparam int STAMP_W         = 64;
	localparam int TAG_W           = 16;
	localparam int FUNC_W          = 2;
	localparam int ACT_W           = 3;
	localparam int REG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 1;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int TAG_BITS_DEF    = 16;

	localparam logic [FUNC_W-1:0] FUNC_PUSH_P = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_I = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	localparam logic [ACT_W-1:0] ACT_FORWARD   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DROP_OLD  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DROP_FULL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REFUSED   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ORDER_ERR = 3'd4;

	localparam logic SRC_PRIMARY = 1'b0;
	localparam logic SRC_INFO    = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_SYNC_POLICY    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_USE_LATEST     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DROP_WHEN_FULL = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [STAMP_W-1:0] stamp;
		logic [TAG_W-1:0]          message_tag;
	} in_t;

	typedef struct packed {
		logic                      source;
		logic [ACT_W-1:0]          action;
		logic signed [STAMP_W-1:0] out_stamp;
		logic [TAG_W-1:0]          out_tag;
		logic                      last;
	} out_t;

	// per-queue commands from the sequencer
	typedef struct packed {
		logic push;
		logic pop;
		logic rd_tail;
		logic scan_start;
		logic scan_step;
	} qctl_t;

	// per-queue status back to the sequencer
	typedef struct packed {
		logic empty;
		logic full;
		logic scan_in_range;
		logic scan_end;
	} qsts_t;

endpackage

/* rtl/tsu_queue.sv */
// Circular queue of timestamped tags held in one synchronous memory
`include "two_stream_timestamp_synchronizer_unit_assert.svh"

module tsu_queue import tsu_pkg::*; #(
	parameter int DEPTH    = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qctl_t                     ctl,
	input  logic signed [STAMP_W-1:0] wr_stamp,
	input  logic [TAG_W-1:0]          wr_tag,
	output qsts_t                     sts,
	output logic signed [STAMP_W-1:0] rd_stamp,
	output logic [TAG_W-1:0]          rd_tag
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int EW = STAMP_W + KW;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] scan_ptr_q;
	logic [CW-1:0] scan_idx_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] head_inc;
	logic [IW-1:0] scan_inc;

	// base plus offset modulo the depth; the sum stays below twice the depth
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign head_inc = wrap_add(head_q, CW'(1));
	assign scan_inc = wrap_add(scan_ptr_q, CW'(1));
	assign wr_addr  = wrap_add(head_q, count_q);

	// look one step ahead so the next head is ready the cycle after a pop
	always_comb begin
		if (ctl.rd_tail) begin
			rd_addr = wrap_add(head_q, count_q - CW'(1));
		end else if (ctl.scan_step) begin
			rd_addr = scan_inc;
		end else if (ctl.pop) begin
			rd_addr = head_inc;
		end else begin
			rd_addr = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_addr] <= {wr_stamp, wr_tag[KW-1:0]};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			scan_ptr_q <= '0;
			scan_idx_q <= '0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CW'(1);
				head_q  <= head_inc;
			end
			if (ctl.scan_start) begin
				scan_ptr_q <= head_q;
				scan_idx_q <= '0;
			end else if (ctl.scan_step) begin
				scan_ptr_q <= scan_inc;
				scan_idx_q <= scan_idx_q + CW'(1);
			end
		end
	end

	assign rd_stamp          = rd_q[EW-1:KW];
	assign rd_tag            = TAG_W'(rd_q[KW-1:0]);
	assign sts.empty         = (count_q == '0);
	assign sts.full          = (count_q == FULL_CNT);
	assign sts.scan_in_range = (scan_idx_q < count_q);
	assign sts.scan_end      = ((CW+1)'(scan_idx_q) + (CW+1)'(1)) >= (CW+1)'(count_q);

	`TSU_ASSERT_IMP(a_no_push_full, ctl.push, !sts.full, "push into a full queue")
	`TSU_ASSERT_IMP(a_no_pop_empty, ctl.pop, !sts.empty, "pop from an empty queue")
	`TSU_ASSERT_IMP(a_count_bound, 1'b1, count_q <= FULL_CNT, "queue count past depth")

endmodule

/* rtl/two_stream_timestamp_synchronizer_unit.sv */
// Push: busy stays low; a refused push puts its result word out on the next cycle.
// Tick (both queues live, use-latest off): form the candidate, scan the queue positions
// (the longer queue sets how many), then on a match form one result word per cycle, each
// shown the cycle after. Use-latest forwards both heads; drop-when-full drops full heads.
// Result words are one-cycle strobes; the receiver cannot stall them.
// Reset clears heads, counts and config; queue memory contents stay as they are.
`include "two_stream_timestamp_synchronizer_unit_assert.svh"

module two_stream_timestamp_synchronizer_unit import tsu_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_t                   item,
	output logic                  res_strobe,
	output out_t                  result,
	input  logic                  cfg_wr_en,
	input  logic [REG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int KW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVAL   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_WALK_I = 4'd3;
	localparam logic [3:0] S_WALK_P = 4'd4;
	localparam logic [3:0] S_DROP_P = 4'd5;
	localparam logic [3:0] S_DROP_I = 4'd6;
	localparam logic [3:0] S_LAT_P  = 4'd7;
	localparam logic [3:0] S_LAT_I  = 4'd8;

	logic [3:0]                state_q, state_d;
	logic                      sync_policy_q;
	logic                      latest_q;
	logic                      drop_full_q;
	logic                      drop_i_q, drop_i_d;
	logic                      p_hit_q, p_hit_d;
	logic                      i_hit_q, i_hit_d;
	logic signed [STAMP_W-1:0] cand_q, cand_d;
	out_t                      res_q, res_d;
	logic                      res_strobe_q, res_strobe_d;

	qctl_t                     pctl, ictl;
	qsts_t                     psts, ists;
	logic signed [STAMP_W-1:0] p_stamp, i_stamp;
	logic [TAG_W-1:0]          p_tag, i_tag;
	logic [TAG_W-1:0]          tag_in;
	logic                      accept;
	logic                      both_live;
	logic signed [STAMP_W-1:0] pick;
	logic                      p_hit_now, i_hit_now;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign tag_in    = TAG_W'(item.message_tag[KW-1:0]);
	assign both_live = !psts.empty && !ists.empty;
	assign p_hit_now = p_hit_q || (psts.scan_in_range && (p_stamp == cand_q));
	assign i_hit_now = i_hit_q || (ists.scan_in_range && (i_stamp == cand_q));

	// candidate from the words read at the tails or heads
	always_comb begin
		if (sync_policy_q) begin
			pick = (p_stamp < i_stamp) ? p_stamp : i_stamp;
		end else begin
			pick = (p_stamp > i_stamp) ? p_stamp : i_stamp;
			if (pick[STAMP_W-1]) begin
				pick = '0;
			end
		end
	end

	tsu_queue #(.DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)) u_primary (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pctl),
		.wr_stamp (item.stamp),
		.wr_tag   (tag_in),
		.sts      (psts),
		.rd_stamp (p_stamp),
		.rd_tag   (p_tag)
	);

	tsu_queue #(.DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)) u_info (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ictl),
		.wr_stamp (item.stamp),
		.wr_tag   (tag_in),
		.sts      (ists),
		.rd_stamp (i_stamp),
		.rd_tag   (i_tag)
	);

	always_comb begin
		state_d      = state_q;
		drop_i_d     = drop_i_q;
		p_hit_d      = p_hit_q;
		i_hit_d      = i_hit_q;
		cand_d       = cand_q;
		res_d        = res_q;
		res_strobe_d = 1'b0;
		pctl         = '0;
		ictl         = '0;
		unique case (state_q)
			S_IDLE: begin
				// read the tails up front for the newest-of-slowest policy
				pctl.rd_tail = sync_policy_q && !latest_q && both_live;
				ictl.rd_tail = sync_policy_q && !latest_q && both_live;
				if (accept) begin
					unique case (item.func) inside
						FUNC_PUSH_P, FUNC_PUSH_I: begin
							if ((item.func == FUNC_PUSH_P) ? psts.full : ists.full) begin
								res_d.source    = (item.func == FUNC_PUSH_P) ? SRC_PRIMARY
									: SRC_INFO;
								res_d.action    = ACT_REFUSED;
								res_d.out_stamp = item.stamp;
								res_d.out_tag   = tag_in;
								res_d.last      = 1'b1;
								res_strobe_d    = 1'b1;
							end else if (item.func == FUNC_PUSH_P) begin
								pctl.push = 1'b1;
							end else begin
								ictl.push = 1'b1;
							end
						end
						FUNC_TICK: begin
							if (!both_live) begin
								drop_i_d = drop_full_q && ists.full;
								if (drop_full_q && psts.full) begin
									state_d = S_DROP_P;
								end else if (drop_full_q && ists.full) begin
									state_d = S_DROP_I;
								end
							end else if (latest_q) begin
								state_d = S_LAT_P;
							end else begin
								state_d = S_EVAL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_EVAL: begin
				cand_d          = pick;
				p_hit_d         = 1'b0;
				i_hit_d         = 1'b0;
				pctl.scan_start = 1'b1;
				ictl.scan_start = 1'b1;
				state_d         = S_SCAN;
			end
			S_SCAN: begin
				if (psts.scan_end && ists.scan_end) begin
					state_d = (p_hit_now && i_hit_now) ? S_WALK_I : S_IDLE;
				end else begin
					pctl.scan_step = 1'b1;
					ictl.scan_step = 1'b1;
					p_hit_d        = p_hit_now;
					i_hit_d        = i_hit_now;
				end
			end
			S_WALK_I: begin
				res_d.source    = SRC_INFO;
				res_d.out_stamp = i_stamp;
				res_d.out_tag   = i_tag;
				res_strobe_d    = 1'b1;
				if (i_stamp == cand_q) begin
					res_d.action = ACT_FORWARD;
					res_d.last   = 1'b0;
					ictl.pop     = 1'b1;
					state_d      = S_WALK_P;
				end else if (i_stamp < cand_q) begin
					res_d.action = ACT_DROP_OLD;
					res_d.last   = 1'b0;
					ictl.pop     = 1'b1;
				end else begin
					// newer entry ahead of the match: report it and keep it queued
					res_d.action = ACT_ORDER_ERR;
					res_d.last   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_WALK_P: begin
				res_d.source    = SRC_PRIMARY;
				res_d.out_stamp = p_stamp;
				res_d.out_tag   = p_tag;
				res_strobe_d    = 1'b1;
				if (p_stamp == cand_q) begin
					res_d.action = ACT_FORWARD;
					res_d.last   = 1'b1;
					pctl.pop     = 1'b1;
					state_d      = S_IDLE;
				end else if (p_stamp < cand_q) begin
					res_d.action = ACT_DROP_OLD;
					res_d.last   = 1'b0;
					pctl.pop     = 1'b1;
				end else begin
					res_d.action = ACT_ORDER_ERR;
					res_d.last   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_DROP_P: begin
				res_d.source    = SRC_PRIMARY;
				res_d.action    = ACT_DROP_FULL;
				res_d.out_stamp = p_stamp;
				res_d.out_tag   = p_tag;
				res_d.last      = !drop_i_q;
				res_strobe_d    = 1'b1;
				pctl.pop        = 1'b1;
				state_d         = drop_i_q ? S_DROP_I : S_IDLE;
			end
			S_DROP_I: begin
				res_d.source    = SRC_INFO;
				res_d.action    = ACT_DROP_FULL;
				res_d.out_stamp = i_stamp;
				res_d.out_tag   = i_tag;
				res_d.last      = 1'b1;
				res_strobe_d    = 1'b1;
				ictl.pop        = 1'b1;
				state_d         = S_IDLE;
			end
			S_LAT_P: begin
				res_d.source    = SRC_PRIMARY;
				res_d.action    = ACT_FORWARD;
				res_d.out_stamp = p_stamp;
				res_d.out_tag   = p_tag;
				res_d.last      = 1'b0;
				res_strobe_d    = 1'b1;
				cand_d          = p_stamp;
				pctl.pop        = 1'b1;
				state_d         = S_LAT_I;
			end
			S_LAT_I: begin
				// info word goes out under the primary timestamp
				res_d.source    = SRC_INFO;
				res_d.action    = ACT_FORWARD;
				res_d.out_stamp = cand_q;
				res_d.out_tag   = i_tag;
				res_d.last      = 1'b1;
				res_strobe_d    = 1'b1;
				ictl.pop        = 1'b1;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			drop_i_q      <= 1'b0;
			p_hit_q       <= 1'b0;
			i_hit_q       <= 1'b0;
			res_strobe_q  <= 1'b0;
			sync_policy_q <= 1'b0;
			latest_q      <= 1'b0;
			drop_full_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			drop_i_q     <= drop_i_d;
			p_hit_q      <= p_hit_d;
			i_hit_q      <= i_hit_d;
			res_strobe_q <= res_strobe_d;
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					REG_SYNC_POLICY:    sync_policy_q <= cfg_wdata[0];
					REG_USE_LATEST:     latest_q      <= cfg_wdata[0];
					REG_DROP_WHEN_FULL: drop_full_q   <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= cand_d;
		res_q  <= res_d;
	end

	assign res_strobe = res_strobe_q;
	assign result     = res_q;

	`TSU_ASSERT_NXT(a_push_one_cycle, accept && item.func != FUNC_TICK, !busy, "push held busy")
	`TSU_ASSERT_IMP(a_last_ends_item, res_strobe_q && res_q.last, !busy, "busy after last word")
	`TSU_ASSERT_IMP(a_walk_i_live, state_q == S_WALK_I, !ists.empty, "info walk on empty queue")
	`TSU_ASSERT_IMP(a_walk_p_live, state_q == S_WALK_P, !psts.empty, "primary walk on empty queue")

endmodule
